// ===== design/assert_macros.svh =====
// assertion macros used by the scalar reliability smoother design
// no dependencies; clock and reset are taken from the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SKR_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// next-cycle implication checked outside reset
`define SKR_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/skr_pkg.sv =====
// shared constants and types of the scalar reliability smoother
// no dependencies
package skr_pkg;

   localparam int CFG_W   = 24;
   localparam int CSR_DW  = 32;
   localparam int CSR_AW  = 4;

   typedef enum logic [1:0] {
      REG_FILTER_ENABLE,
      REG_INITIAL_VARIANCE,
      REG_PROCESS_NOISE,
      REG_MEASUREMENT_NOISE
   } reg_index_type;

endpackage

// ===== design/skr_channels.sv =====
// valid/ready channel interfaces of the scalar reliability smoother
// no dependencies; widths follow the fraction and variance parameters
interface skr_req_if #(
   parameter int FRACTION_BITS = 16
);
   logic                     valid;
   logic                     ready;
   logic [FRACTION_BITS:0]   probability;

   modport source (output valid, output probability, input ready);
   modport sink   (input valid, input probability, output ready);
endinterface

interface skr_rsp_if #(
   parameter int FRACTION_BITS = 16,
   parameter int VARIANCE_BITS = 24
);
   logic                       valid;
   logic                       ready;
   logic [FRACTION_BITS:0]     reliability_out;
   logic [VARIANCE_BITS-1:0]   variance_out;
   logic                       restarted;

   modport source (output valid, output reliability_out, output variance_out,
                   output restarted, input ready);
   modport sink   (input valid, input reliability_out, input variance_out,
                   input restarted, output ready);
endinterface

// ===== design/scalar_kalman_reliability.sv =====
// scalar kalman reliability smoother, uses skr_pkg, skr_channels, assert_macros.svh
// filtered transaction: idle, noise, gain load, bit-serial restoring divide, shift-add
// multiply, update and finish states in order; finish loads the output register once free
// restart or bypass transaction: idle goes straight to finish, then to the output register
// one transaction in flight; the next is accepted while a result waits in the output register
// synchronous active-high reset; no clearing pass, state, settings and flags load at once
`include "assert_macros.svh"

module scalar_kalman_reliability #(
   parameter int FRACTION_BITS = 16,
   parameter int VARIANCE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   skr_req_if.sink                      req_chan,
   skr_rsp_if.source                    rsp_chan,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [skr_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [skr_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [skr_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int PW = FRACTION_BITS + 1;
   localparam int VW = VARIANCE_BITS;
   localparam int WW = ((VW > skr_pkg::CFG_W) ? VW : skr_pkg::CFG_W) + 1;
   localparam int CW = $clog2(PW);
   localparam int EW = 2 * PW;
   localparam int AW = VW + PW;

   localparam logic [PW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic [63:0] VMAX64 = (64'd1 << VARIANCE_BITS) - 64'd1;
   localparam logic [63:0] VAR4_64 = 64'd4 << FRACTION_BITS;
   localparam logic [WW-1:0] VMAX_W = WW'(VMAX64);
   localparam logic [VW-1:0] VAR_RESET = (VAR4_64 > VMAX64) ? VMAX64[VW-1:0] : VAR4_64[VW-1:0];
   localparam logic [skr_pkg::CFG_W-1:0] INIT_VAR_RESET = skr_pkg::CFG_W'(VAR4_64);
   localparam logic [skr_pkg::CFG_W-1:0] PROC_NOISE_RESET =
      skr_pkg::CFG_W'(((64'd1 << FRACTION_BITS) + 64'd50) / 64'd100);
   localparam logic [skr_pkg::CFG_W-1:0] MEAS_NOISE_RESET =
      skr_pkg::CFG_W'(64'd1 << FRACTION_BITS);
   localparam logic [CW-1:0] LAST_BIT = CW'(FRACTION_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NOISE,
      ST_GAIN_LOAD,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic                         enable_ff, enable_in;
   logic [skr_pkg::CFG_W-1:0]    init_var_ff, init_var_in;
   logic [skr_pkg::CFG_W-1:0]    proc_noise_ff, proc_noise_in;
   logic [skr_pkg::CFG_W-1:0]    meas_noise_ff, meas_noise_in;
   logic                         valid_ff, valid_in;
   logic [PW-1:0]                est_ff, est_in;
   logic [VW-1:0]                var_ff, var_in;
   logic                         restart_ff, restart_in;
   logic [PW-1:0]                sample_ff, sample_in;
   logic [VW-1:0]                p1_ff, p1_in;
   logic [WW-1:0]                den_ff, den_in;
   logic [WW-1:0]                rem_ff, rem_in;
   logic                         den_zero_ff, den_zero_in;
   logic [PW-1:0]                quot_ff, quot_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         neg_ff, neg_in;
   logic [PW-1:0]                ae_ff, ae_in;
   logic [PW-1:0]                mk_ff, mk_in;
   logic [PW-1:0]                mv_ff, mv_in;
   logic [EW-1:0]                acc_e_ff, acc_e_in;
   logic [AW-1:0]                acc_v_ff, acc_v_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                rsp_est_ff, rsp_est_in;
   logic [VW-1:0]                rsp_var_ff, rsp_var_in;
   logic                         rsp_rst_ff, rsp_rst_in;

   logic                         cfg_write;
   skr_pkg::reg_index_type       cfg_index;
   logic [WW-1:0]                init_w;
   logic [VW-1:0]                init_sat;
   logic [WW-1:0]                noise_sum;
   logic [WW:0]                  shifted;
   logic                         quot_bit;
   logic [PW-1:0]                gain;
   logic [PW-1:0]                mag;
   logic [PW:0]                  est_up;

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = skr_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (cfg_index)
         skr_pkg::REG_FILTER_ENABLE:     csr_prdata = skr_pkg::CSR_DW'(enable_ff);
         skr_pkg::REG_INITIAL_VARIANCE:  csr_prdata = skr_pkg::CSR_DW'(init_var_ff);
         skr_pkg::REG_PROCESS_NOISE:     csr_prdata = skr_pkg::CSR_DW'(proc_noise_ff);
         skr_pkg::REG_MEASUREMENT_NOISE: csr_prdata = skr_pkg::CSR_DW'(meas_noise_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.reliability_out = rsp_est_ff;
   assign rsp_chan.variance_out    = rsp_var_ff;
   assign rsp_chan.restarted       = rsp_rst_ff;

   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      init_var_in   = init_var_ff;
      proc_noise_in = proc_noise_ff;
      meas_noise_in = meas_noise_ff;
      valid_in      = valid_ff;
      est_in        = est_ff;
      var_in        = var_ff;
      restart_in    = restart_ff;
      sample_in     = sample_ff;
      p1_in         = p1_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      den_zero_in   = den_zero_ff;
      quot_in       = quot_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      ae_in         = ae_ff;
      mk_in         = mk_ff;
      mv_in         = mv_ff;
      acc_e_in      = acc_e_ff;
      acc_v_in      = acc_v_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_est_in    = rsp_est_ff;
      rsp_var_in    = rsp_var_ff;
      rsp_rst_in    = rsp_rst_ff;

      init_w    = WW'(init_var_ff);
      init_sat  = (init_w > VMAX_W) ? VMAX_W[VW-1:0] : init_w[VW-1:0];
      noise_sum = WW'(var_ff) + WW'(proc_noise_ff);
      shifted   = (cnt_ff == LAST_BIT) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      quot_bit  = (shifted >= {1'b0, den_ff});
      gain      = den_zero_ff ? '0 : {quot_ff[PW-2:0], quot_bit};
      mag       = acc_e_ff[FRACTION_BITS +: PW];
      est_up    = {1'b0, est_ff} + {1'b0, mag};

      if (cfg_write) begin
         unique case (cfg_index)
            skr_pkg::REG_FILTER_ENABLE:     enable_in     = csr_pwdata[0];
            skr_pkg::REG_INITIAL_VARIANCE:  init_var_in   = csr_pwdata[skr_pkg::CFG_W-1:0];
            skr_pkg::REG_PROCESS_NOISE:     proc_noise_in = csr_pwdata[skr_pkg::CFG_W-1:0];
            skr_pkg::REG_MEASUREMENT_NOISE: meas_noise_in = csr_pwdata[skr_pkg::CFG_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sample_in = (req_chan.probability > ONE) ? ONE : req_chan.probability;
               if (!valid_ff || !enable_ff) begin
                  est_in     = (req_chan.probability > ONE) ? ONE : req_chan.probability;
                  var_in     = init_sat;
                  valid_in   = 1'b1;
                  restart_in = 1'b1;
                  state_in   = ST_FINISH;
               end else begin
                  restart_in = 1'b0;
                  state_in   = ST_NOISE;
               end
            end
         end
         ST_NOISE: begin
            p1_in    = (noise_sum > VMAX_W) ? VMAX_W[VW-1:0] : noise_sum[VW-1:0];
            neg_in   = (sample_ff < est_ff);
            ae_in    = (sample_ff < est_ff) ? (est_ff - sample_ff) : (sample_ff - est_ff);
            state_in = ST_GAIN_LOAD;
         end
         ST_GAIN_LOAD: begin
            den_in      = WW'(p1_ff) + WW'(meas_noise_ff);
            den_zero_in = ((WW'(p1_ff) + WW'(meas_noise_ff)) == '0);
            rem_in      = WW'(p1_ff);
            quot_in     = '0;
            cnt_in      = LAST_BIT;
            state_in    = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in  = quot_bit ? WW'(shifted - {1'b0, den_ff}) : shifted[WW-1:0];
            quot_in = {quot_ff[PW-2:0], quot_bit};
            if (cnt_ff == '0) begin
               mk_in    = gain;
               mv_in    = ONE - gain;
               acc_e_in = '0;
               acc_v_in = '0;
               cnt_in   = LAST_BIT;
               state_in = ST_MULTIPLY;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_MULTIPLY: begin
            acc_e_in = {acc_e_ff[EW-2:0], 1'b0} + (mk_ff[PW-1] ? EW'(ae_ff) : '0);
            acc_v_in = {acc_v_ff[AW-2:0], 1'b0} + (mv_ff[PW-1] ? AW'(p1_ff) : '0);
            mk_in    = {mk_ff[PW-2:0], 1'b0};
            mv_in    = {mv_ff[PW-2:0], 1'b0};
            if (cnt_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         ST_UPDATE: begin
            if (neg_ff) begin
               est_in = est_ff - mag;
            end else begin
               est_in = (est_up > {1'b0, ONE}) ? ONE : est_up[PW-1:0];
            end
            var_in   = acc_v_ff[FRACTION_BITS +: VW];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_est_in   = est_ff;
               rsp_var_in   = var_ff;
               rsp_rst_in   = restart_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= 1'b1;
         init_var_ff   <= INIT_VAR_RESET;
         proc_noise_ff <= PROC_NOISE_RESET;
         meas_noise_ff <= MEAS_NOISE_RESET;
         valid_ff      <= 1'b0;
         est_ff        <= '0;
         var_ff        <= VAR_RESET;
         restart_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         enable_ff     <= enable_in;
         init_var_ff   <= init_var_in;
         proc_noise_ff <= proc_noise_in;
         meas_noise_ff <= meas_noise_in;
         valid_ff      <= valid_in;
         est_ff        <= est_in;
         var_ff        <= var_in;
         restart_ff    <= restart_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
      end
      sample_ff   <= sample_in;
      p1_ff       <= p1_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      den_zero_ff <= den_zero_in;
      quot_ff     <= quot_in;
      neg_ff      <= neg_in;
      ae_ff       <= ae_in;
      mk_ff       <= mk_in;
      mv_ff       <= mv_in;
      acc_e_ff    <= acc_e_in;
      acc_v_ff    <= acc_v_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_rst_ff  <= rsp_rst_in;
   end

   `SKR_ASSERT_NEXT(a_accept_leaves_idle, req_chan.valid && req_chan.ready, state_ff != ST_IDLE, "accepted transaction did not start")
   `SKR_ASSERT(a_estimate_in_range, est_ff <= ONE, "estimate above one")
   `SKR_ASSERT(a_rsp_from_finish, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH), "result loaded outside finish")
   `SKR_ASSERT_NEXT(a_variance_shrinks, state_ff == ST_UPDATE, var_ff <= $past(p1_ff), "corrected variance above predicted")

endmodule
